// ===== hw/rtl/texture_sampler_filtered_assert.svh =====
// Assertion macros for the texture sampler.
// Needs clk and arst_n in the scope that uses them.
`ifndef TEXTURE_SAMPLER_FILTERED_ASSERT_SVH
`define TEXTURE_SAMPLER_FILTERED_ASSERT_SVH

// Same-cycle implication.
`define TSF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tsf_pkg.sv =====
// Shared types, constants and helper functions of the texture sampler.
// No dependencies.
package tsf_pkg;

	localparam int MAX_DIM     = 256;
	localparam int LOG_DIM     = 8;
	localparam int MAX_LEVELS  = 9;
	localparam int WEIGHT_BITS = 8;
	localparam int ADDR_W      = 17;

	typedef enum logic [2:0] {
		REG_FILTER_MODE = 3'd0,
		REG_WRAP_U      = 3'd1,
		REG_WRAP_V      = 3'd2,
		REG_TEX_WIDTH   = 3'd3,
		REG_TEX_HEIGHT  = 3'd4,
		REG_LEVEL_COUNT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		FILT_NEAREST   = 2'd0,
		FILT_BILINEAR  = 2'd1,
		FILT_TRILINEAR = 2'd2
	} filt_t;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Saturate a size register to 1..MAX_DIM.
	function automatic logic [8:0] sat_dim(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) r = 9'd1;
		else if (v > 9'(MAX_DIM)) r = 9'(MAX_DIM);
		else r = v;
		return r;
	endfunction

	// Size of a mip level, never below one.
	function automatic logic [8:0] level_size(input logic [8:0] base, input logic [3:0] lvl);
		logic [8:0] d;
		d = base >> lvl;
		return (d == 9'd0) ? 9'd1 : d;
	endfunction

	// First address of a level in the texel memory.
	function automatic logic [ADDR_W-1:0] level_base(input logic [3:0] lvl);
		logic [ADDR_W-1:0] b;
		b = '0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (4'(k) < lvl) b = b + ADDR_W'((MAX_DIM >> k) * (MAX_DIM >> k));
		end
		return b;
	endfunction

	// Map a coordinate in -1..extent onto 0..extent-1.
	function automatic logic [7:0] resolve(input logic signed [10:0] c,
			input logic [8:0] ext, input logic rep);
		logic [8:0] r;
		if (c < 0) r = rep ? ext - 9'd1 : 9'd0;
		else if (c >= $signed({2'b00, ext})) r = rep ? 9'd0 : ext - 9'd1;
		else r = c[8:0];
		return r[7:0];
	endfunction

	// Wrap a Q15.16 coordinate into Q1.16, 0..1.0.
	function automatic logic [16:0] wrap_coord(input logic signed [31:0] raw, input logic rep);
		logic [16:0] r;
		if (rep) r = {1'b0, raw[15:0]};
		else if (raw <= 0) r = 17'd0;
		else if (raw >= 32'sd65536) r = 17'd65536;
		else r = raw[16:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/tsf_chan_if.sv =====
// Request and result channels of the texture sampler.
// Depends on nothing; payload widths follow the block's fields.
interface tsf_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [3:0]         mip_level;
	logic [7:0]         texel_x;
	logic [7:0]         texel_y;
	logic [31:0]        texel_rgba;
	logic signed [31:0] u_coord;
	logic signed [31:0] v_coord;
	logic signed [13:0] level_of_detail;

	modport source(output valid, command, mip_level, texel_x, texel_y, texel_rgba,
		u_coord, v_coord, level_of_detail, input ready);
	modport sink(input valid, command, mip_level, texel_x, texel_y, texel_rgba,
		u_coord, v_coord, level_of_detail, output ready);
endinterface

interface tsf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source(output valid, red, green, blue, alpha, input ready);
	modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

// ===== hw/rtl/texture_sampler_filtered.sv =====
// Texture sampler top level: texel memory, sequencer and filter datapath.
// Depends on tsf_pkg, tsf_chan_if and texture_sampler_filtered_assert.svh.
//
// Holds an RGBA8 texture with up to nine mip levels in one single-port
// 128K x 32 texel memory (registered read, contents undefined until
// written). A sample request is handled one at a time by a sequencer
// around that memory port: per level it runs SETUP and ADDR, issues the
// texel reads in READ (1 for nearest, 4 for bilinear), waits in DRAIN for
// the last read, and lerps in LERPX and LERPY (skipped by nearest); then
// BLEND blends and rounds, and DONE loads the output register once it is
// free. The memory port, one texel a cycle, sets the read phase.
// The output register holds a finished result while the next request is
// taken. Configuration goes through the APB port at byte address 4*i.
`include "texture_sampler_filtered_assert.svh"

module texture_sampler_filtered (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tsf_req_if.sink     req,
	tsf_rsp_if.source   rsp
);
	import tsf_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_WRITE = 10'b0000000010,
		ST_SETUP = 10'b0000000100,
		ST_ADDR  = 10'b0000001000,
		ST_READ  = 10'b0000010000,
		ST_DRAIN = 10'b0000100000,
		ST_LERPX = 10'b0001000000,
		ST_LERPY = 10'b0010000000,
		ST_BLEND = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	// ---------------- configuration registers ----------------
	logic [1:0] filter_mode_q;
	logic       wrap_u_q, wrap_v_q;
	logic [8:0] tex_width_q, tex_height_q;
	logic [3:0] level_count_q;
	logic       cfg_we;
	reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= 2'd1;
			wrap_u_q      <= 1'b0;
			wrap_v_q      <= 1'b0;
			tex_width_q   <= 9'd1;
			tex_height_q  <= 9'd1;
			level_count_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FILTER_MODE: filter_mode_q <= pwdata[1:0];
				REG_WRAP_U:      wrap_u_q      <= pwdata[0];
				REG_WRAP_V:      wrap_v_q      <= pwdata[0];
				REG_TEX_WIDTH:   tex_width_q   <= pwdata[8:0];
				REG_TEX_HEIGHT:  tex_height_q  <= pwdata[8:0];
				REG_LEVEL_COUNT: level_count_q <= pwdata[3:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FILTER_MODE: prdata = {30'd0, filter_mode_q};
			REG_WRAP_U:      prdata = {31'd0, wrap_u_q};
			REG_WRAP_V:      prdata = {31'd0, wrap_v_q};
			REG_TEX_WIDTH:   prdata = {23'd0, tex_width_q};
			REG_TEX_HEIGHT:  prdata = {23'd0, tex_height_q};
			REG_LEVEL_COUNT: prdata = {28'd0, level_count_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Effective sizes after saturation.
	logic [8:0] sat_w, sat_h;
	logic [3:0] eff_lc;
	assign sat_w  = sat_dim(tex_width_q);
	assign sat_h  = sat_dim(tex_height_q);
	assign eff_lc = (level_count_q == 4'd0) ? 4'd1 :
		(level_count_q > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : level_count_q;

	// ---------------- request capture ----------------
	state_t state_q;
	logic   req_fire;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid & req.ready;

	// Filter choice: filter code 3 and trilinear on one level fall back to bilinear.
	filt_t mode_new;
	always_comb begin
		if (filter_mode_q == FILT_NEAREST) mode_new = FILT_NEAREST;
		else if (filter_mode_q == FILT_TRILINEAR && eff_lc > 4'd1) mode_new = FILT_TRILINEAR;
		else mode_new = FILT_BILINEAR;
	end

	// Clamp the level of detail and pick the two levels and their blend weight.
	logic signed [13:0] lod_top;
	logic [11:0]        lod_c;
	logic [3:0]         l0_new, l1_new;
	logic [7:0]         lf_new;
	always_comb begin
		lod_top = 14'(signed'({1'b0, eff_lc - 4'd1, 8'd0}));
		if (req.level_of_detail < 0) lod_c = 12'd0;
		else if (req.level_of_detail > lod_top) lod_c = lod_top[11:0];
		else lod_c = req.level_of_detail[11:0];
		l0_new = lod_c[11:8];
		lf_new = lod_c[7:0];
		l1_new = l0_new + 4'd1;
		if (l1_new >= eff_lc) begin
			l1_new = eff_lc - 4'd1;
			lf_new = 8'd0;
		end
	end

	logic        cmd_q;
	logic [3:0]  wlvl_q;
	logic [7:0]  wx_q, wy_q;
	logic [31:0] wdata_q;
	logic [16:0] su_q, sv_q;
	filt_t       mode_q;
	logic [3:0]  lvl_q, l1_q;
	logic [7:0]  lf_q;
	logic        second_q;

	// ---------------- texel memory ----------------
	logic [31:0]       mem [2**ADDR_W];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [31:0]       rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= wdata_q;
		else rdata_q <= mem[mem_addr];
	end

	// Write path: drop texels outside the level's size or beyond the last level.
	logic       wr_ok;
	logic [3:0] wshift;
	assign wshift = 4'(LOG_DIM) - wlvl_q;
	assign wr_ok  = (wlvl_q < 4'(MAX_LEVELS))
		&& ({1'b0, wx_q} < level_size(sat_w, wlvl_q))
		&& ({1'b0, wy_q} < level_size(sat_h, wlvl_q));

	// ---------------- sample datapath ----------------
	logic [8:0]  lw, lh;
	logic [25:0] px_q, py_q;
	logic [25:0] half;
	logic [7:0]  ax_q, bx_q, ay_q, by_q;
	logic [7:0]  fx_q, fy_q;
	logic [1:0]  rd_cnt_q;
	logic        rd_last;
	logic        rd_vld_s1;
	logic [1:0]  rd_idx_s1;
	logic [31:0] tex_q [4];
	logic [7:0]  rx, ry;
	logic [3:0]  rshift;
	logic [ADDR_W-1:0] rd_addr;

	assign lw   = level_size(sat_w, lvl_q);
	assign lh   = level_size(sat_h, lvl_q);
	assign half = (mode_q == FILT_NEAREST) ? 26'd0 : 26'd32768;

	// Nearest reads only the first corner.
	assign rd_last = (mode_q == FILT_NEAREST) || (rd_cnt_q == 2'd3);
	assign rx      = rd_cnt_q[0] ? bx_q : ax_q;
	assign ry      = rd_cnt_q[1] ? by_q : ay_q;
	assign rshift  = 4'(LOG_DIM) - lvl_q;
	assign rd_addr = level_base(lvl_q) + (ADDR_W'(ry) << rshift) + ADDR_W'(rx);

	always_comb begin
		mem_we   = (state_q == ST_WRITE) && wr_ok;
		mem_addr = (state_q == ST_WRITE)
			? level_base(wlvl_q) + (ADDR_W'(wy_q) << wshift) + ADDR_W'(wx_q)
			: rd_addr;
	end

	// Horizontal then vertical lerp, exact in fixed point.
	logic [15:0] top_n [4], bot_n [4];
	logic [15:0] top_q [4], bot_q [4];
	logic [23:0] acc_n [4];
	logic [23:0] acc_q [2][4];
	logic [8:0]  wfx, wfy, wlf;
	logic [7:0]  res_n [4];
	logic [7:0]  res_q [4];
	logic [32:0] blend_sum;
	logic [24:0] bil_sum;

	assign wfx = 9'(1 << WEIGHT_BITS) - {1'b0, fx_q};
	assign wfy = 9'(1 << WEIGHT_BITS) - {1'b0, fy_q};
	assign wlf = 9'(1 << WEIGHT_BITS) - {1'b0, lf_q};

	always_comb begin
		blend_sum = '0;
		bil_sum   = '0;
		for (int c = 0; c < 4; c++) begin
			top_n[c] = 16'(17'(tex_q[0][8*c +: 8]) * 17'(wfx)
				+ 17'(tex_q[1][8*c +: 8]) * 17'(fx_q));
			bot_n[c] = 16'(17'(tex_q[2][8*c +: 8]) * 17'(wfx)
				+ 17'(tex_q[3][8*c +: 8]) * 17'(fx_q));
			acc_n[c] = 24'(25'(top_q[c]) * 25'(wfy) + 25'(bot_q[c]) * 25'(fy_q));
			case (mode_q)
				FILT_NEAREST: res_n[c] = tex_q[0][8*c +: 8];
				FILT_TRILINEAR: begin
					blend_sum = 33'(acc_q[0][c]) * 33'(wlf) + 33'(acc_q[1][c]) * 33'(lf_q)
						+ 33'(1 << (3*WEIGHT_BITS - 1));
					res_n[c] = blend_sum[31:24];
				end
				default: begin
					bil_sum  = 25'(acc_q[0][c]) + 25'(1 << (2*WEIGHT_BITS - 1));
					res_n[c] = bil_sum[23:16];
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q   <= req.command;
			wlvl_q  <= req.mip_level;
			wx_q    <= req.texel_x;
			wy_q    <= req.texel_y;
			wdata_q <= req.texel_rgba;
			su_q    <= wrap_coord(req.u_coord, wrap_u_q);
			sv_q    <= wrap_coord(req.v_coord, wrap_v_q);
			mode_q  <= mode_new;
			l1_q    <= l1_new;
			lf_q    <= lf_new;
		end
		if (state_q == ST_SETUP) begin
			px_q <= 26'(su_q) * 26'(lw) + half;
			py_q <= 26'(sv_q) * 26'(lh) + half;
		end
		if (state_q == ST_ADDR) begin
			// Nearest uses the integer part as is; bilinear starts one to the left and one up.
			if (mode_q == FILT_NEAREST) begin
				ax_q <= resolve(11'(signed'({1'b0, px_q[25:16]})), lw, wrap_u_q);
				ay_q <= resolve(11'(signed'({1'b0, py_q[25:16]})), lh, wrap_v_q);
			end else begin
				ax_q <= resolve(11'(signed'({1'b0, px_q[25:16]})) - 11'sd1, lw, wrap_u_q);
				ay_q <= resolve(11'(signed'({1'b0, py_q[25:16]})) - 11'sd1, lh, wrap_v_q);
			end
			bx_q <= resolve(11'(signed'({1'b0, px_q[25:16]})), lw, wrap_u_q);
			by_q <= resolve(11'(signed'({1'b0, py_q[25:16]})), lh, wrap_v_q);
			fx_q <= px_q[15:8];
			fy_q <= py_q[15:8];
		end
		if (rd_vld_s1) tex_q[rd_idx_s1] <= rdata_q;
		if (state_q == ST_LERPX) begin
			top_q <= top_n;
			bot_q <= bot_n;
		end
		if (state_q == ST_LERPY) acc_q[second_q] <= acc_n;
		if (state_q == ST_BLEND) res_q <= res_n;
	end

	// ---------------- sequencer ----------------
	logic out_free;
	assign out_free = !rsp.valid || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= 2'd0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= 2'd0;
			lvl_q     <= 4'd0;
			second_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			rd_idx_s1 <= rd_cnt_q;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						lvl_q    <= (mode_new == FILT_TRILINEAR) ? l0_new : 4'd0;
						second_q <= 1'b0;
						state_q  <= (req.command == CMD_WRITE) ? ST_WRITE : ST_SETUP;
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_SETUP: state_q <= ST_ADDR;
				ST_ADDR: begin
					rd_cnt_q <= 2'd0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					// Issue one texel read a cycle; hold for the last one's latency.
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= (mode_q == FILT_NEAREST) ? ST_BLEND : ST_LERPX;
				ST_LERPX: state_q <= ST_LERPY;
				ST_LERPY: begin
					// Trilinear runs the level loop a second time on the upper level.
					if (mode_q == FILT_TRILINEAR && !second_q) begin
						lvl_q    <= l1_q;
						second_q <= 1'b1;
						state_q  <= ST_SETUP;
					end else begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: state_q <= ST_DONE;
				ST_DONE:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- output register ----------------
	logic rsp_valid_q;
	assign rsp.valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp.red   <= res_q[0];
			rsp.green <= res_q[1];
			rsp.blue  <= res_q[2];
			rsp.alpha <= res_q[3];
		end
	end

	// ---------------- assertions ----------------
	`TSF_ASSERT_NEXT(a_leave_idle, req_fire, state_q != ST_IDLE, "sequencer stayed idle")
	`TSF_ASSERT_NOW(a_we_only_write, mem_we, cmd_q == CMD_WRITE, "sample wrote memory")
	`TSF_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == ST_DONE,
		"result without a finished sample")
	`TSF_ASSERT_NOW(a_second_tri, second_q && state_q == ST_LERPY, mode_q == FILT_TRILINEAR,
		"second level outside trilinear")

endmodule
